/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file.
// No dependencies; the clock and reset names clk and rst_n are assumed in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, masked during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, masked during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/scdes_pkg.sv */
// Types, codes and constants for the serial cal-DAC / EEPROM sequencer.
// No dependencies.
package scdes_pkg;

  localparam logic       OP_WRITE_DAC = 1'b0;
  localparam logic       OP_READ_PROM = 1'b1;

  localparam logic [2:0] DAC_NONE     = 3'd0;
  localparam logic [2:0] DAC_REV_NIB  = 3'd1;
  localparam logic [2:0] DAC_ELEVEN   = 3'd2;
  localparam logic [2:0] DAC_VAL_ONLY = 3'd3;
  localparam logic [2:0] DAC_TAGGED   = 3'd4;

  // Phase counts: read is fixed, a write takes two phases per bit plus two.
  localparam logic [5:0] READ_PHASES  = 6'd51;
  localparam logic [5:0] RD_CMD_LAST  = 6'd19;  // lowest phase of the command shift
  localparam logic [5:0] RD_IN_LAST   = 6'd3;   // lowest phase of the data read
  localparam logic [5:0] PH_LOAD      = 6'd2;
  localparam logic [5:0] PH_DONE      = 6'd1;

  typedef struct packed {
    logic        start_req;
    logic        operation;
    logic [2:0]  dac_type;
    logic        dac_select;
    logic [8:0]  address;
    logic [11:0] value;
    logic        prom_in;
  } in_item_t;

  typedef struct packed {
    logic       ser_data;
    logic       ser_clk;
    logic       eeprom_cs;
    logic [1:0] dac_load;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       read_valid;
  } out_item_t;

  // Decoded command handed from the frame builder to the sequencer.
  typedef struct packed {
    logic        ok;         // a command may start from this item
    logic        is_read;
    logic        load_line;
    logic [15:0] frame;      // MSB aligned to bit 15
    logic [5:0]  phases;
  } cmd_t;

  function automatic logic [3:0] nib_rev(input logic [3:0] n);
    nib_rev = {n[0], n[1], n[2], n[3]};
  endfunction

endpackage

/* rtl/core/serial_caldac_eeprom_sequencer_core.sv */
// Top level of the serial cal-DAC / EEPROM sequencer.
// Depends on scdes_pkg and scdes_frame_build.
//
//  channel | dir | payload    | handshake
//  --------+-----+------------+-------------------
//  in_     | in  | in_item_t  | in_valid / in_ready
//  out_    | out | out_item_t | out_valid / out_ready
//
// One transaction in gives one transaction out; one per cycle sustained while out_ready stays high.
// The path holds two registers: input register, then the phase logic into the result register.
// The phase counter and shift registers move only when a transaction crosses into
// the result register, so stalls on either side freeze the sequence exactly.
// Reset (rst_n low, synchronous) returns the sequencer to idle with empty registers.
module serial_caldac_eeprom_sequencer_core #(
  parameter int NUM_LOAD_LINES = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scdes_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scdes_pkg::out_item_t out_data
);
  import scdes_pkg::*;

  // input register
  in_item_t    in_r;
  logic        in_valid_r;
  // result register
  out_item_t   out_r;
  logic        out_valid_r;
  // sequencer state
  logic [5:0]  phase_r,     phase_nxt;
  logic [15:0] shift_r,     shift_nxt;
  logic [7:0]  in_shift_r,  in_shift_nxt;
  logic        is_read_r,   is_read_nxt;
  logic        load_line_r, load_line_nxt;

  cmd_t        cmd;
  logic        adv;
  logic        take;
  logic [5:0]  ph;
  logic [15:0] sh;
  logic [7:0]  ish;
  logic        rd_cmd;
  logic        ldl;
  out_item_t   res;

  // a transaction moves on when the result register is free or being emptied
  assign adv       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  scdes_frame_build u_frame (
    .item (in_r),
    .cmd  (cmd)
  );

  // start only from idle, and only with a valid command
  assign take   = (phase_r == 6'd0) && in_r.start_req && cmd.ok;
  assign ph     = take ? cmd.phases : phase_r;
  assign sh     = take ? cmd.frame : shift_r;
  assign rd_cmd = take ? cmd.is_read : is_read_r;
  assign ldl    = take ? cmd.load_line : load_line_r;
  assign ish    = (take && cmd.is_read) ? 8'd0 : in_shift_r;

  always_comb begin
    res           = '0;
    shift_nxt     = sh;
    in_shift_nxt  = ish;
    is_read_nxt   = rd_cmd;
    load_line_nxt = ldl;
    phase_nxt     = ph;
    if (ph != 6'd0) begin
      res.busy_res = 1'b1;
      phase_nxt    = ph - 6'd1;
      if (!rd_cmd) begin
        if (ph > PH_LOAD) begin
          // data on even phase, clock high on odd phase then shift
          res.ser_data = sh[15];
          if (ph[0]) begin
            res.ser_clk = 1'b1;
            shift_nxt   = {sh[14:0], 1'b0};
          end
        end else if (ph == PH_LOAD) begin
          if (int'(ldl) < NUM_LOAD_LINES) begin
            res.dac_load = 2'b01 << ldl;
          end
        end else begin
          res.done_res = 1'b1;
        end
      end else begin
        if (ph == READ_PHASES) begin
          res.eeprom_cs = 1'b1;        // chip select lead-in
        end else if (ph >= RD_CMD_LAST) begin
          res.eeprom_cs = 1'b1;
          res.ser_data  = sh[15];
          if (ph[0]) begin
            res.ser_clk = 1'b1;
            shift_nxt   = {sh[14:0], 1'b0};
          end
        end else if (ph >= RD_IN_LAST) begin
          res.eeprom_cs = 1'b1;
          if (ph[0]) begin
            res.ser_clk  = 1'b1;
            in_shift_nxt = {ish[6:0], in_r.prom_in};
          end
        end else if (ph == PH_DONE) begin
          res.done_res   = 1'b1;
          res.read_valid = 1'b1;
          res.read_data  = ish;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      shift_r     <= '0;
      in_shift_r  <= '0;
      is_read_r   <= 1'b0;
      load_line_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        shift_r     <= shift_nxt;
        in_shift_r  <= in_shift_nxt;
        is_read_r   <= is_read_nxt;
        load_line_r <= load_line_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= res;
    end
  end

endmodule

/* rtl/core/scdes_frame_build.sv */
// Frame builder: turns a registered transaction into a shift frame and phase count.
// Depends on scdes_pkg.
module scdes_frame_build (
  input  scdes_pkg::in_item_t item,
  output scdes_pkg::cmd_t     cmd
);
  import scdes_pkg::*;

  logic [15:0] tag_bits;

  assign tag_bits = (item.address[7:0] != 8'd0) ? 16'h2000 : 16'h4000;

  always_comb begin
    cmd           = '0;
    cmd.load_line = item.dac_select;
    if (item.operation == OP_READ_PROM) begin
      cmd.ok      = 1'b1;
      cmd.is_read = 1'b1;
      // 0x300 | addr[8] << 11 | addr[7:0]
      cmd.frame   = {4'b0000, item.address[8], 1'b0, 2'b11, item.address[7:0]};
      cmd.phases  = READ_PHASES;
    end else begin
      case (item.dac_type)
        DAC_REV_NIB: begin
          cmd.ok     = 1'b1;
          cmd.frame  = {nib_rev(item.address[3:0]), item.value[7:0], 4'b0000};
          cmd.phases = 6'd26;
        end
        DAC_ELEVEN: begin
          cmd.ok     = 1'b1;
          cmd.frame  = {item.address[2:0], item.value[7:0], 5'b00000};
          cmd.phases = 6'd24;
        end
        DAC_VAL_ONLY: begin
          cmd.ok     = 1'b1;
          cmd.frame  = {item.value, 4'b0000};
          cmd.phases = 6'd26;
        end
        DAC_TAGGED: begin
          cmd.ok     = 1'b1;
          cmd.frame  = 16'h8000 | tag_bits | {4'b0000, item.value};
          cmd.phases = 6'd34;
        end
        default: begin
          cmd.ok = 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/core/scdes_checker.sv */
// Port-level checker for the sequencer top level, with its bind.
// Depends on scdes_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scdes_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input scdes_pkg::out_item_t out_data
);
  import scdes_pkg::*;

  logic load_any;
  logic load_ok;
  logic pins_quiet;

  assign load_any   = out_data.dac_load != 2'b00;
  assign load_ok    = $onehot(out_data.dac_load) && out_data.busy_res && !out_data.eeprom_cs;
  assign pins_quiet = !out_data.ser_clk && !out_data.ser_data && !out_data.eeprom_cs &&
                      !out_data.read_valid;

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // last phase is always part of a command
  `ASSERT_IMPL(a_done_busy, out_valid && out_data.done_res, out_data.busy_res)
  // byte only appears on the closing phase
  `ASSERT_IMPL(a_rv_done, out_valid && out_data.read_valid, out_data.done_res)
  // load strobe is one-hot and never during an EEPROM access
  `ASSERT_IMPL(a_load_ok, out_valid && load_any, load_ok)
  // idle phase drives the serial pins, chip select and read strobe low
  `ASSERT_IMPL(a_idle_quiet, out_valid && !out_data.busy_res, pins_quiet)

endmodule

bind serial_caldac_eeprom_sequencer_core scdes_checker u_scdes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
